// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the RTL file that carries concurrent checks.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_IMPLIES_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

// ----- rtl/core/mau_pkg.sv -----
// Package for the multiply-accumulate unit: beat types, operation codes and
// the stage enable bundle. No dependencies.
package mau_pkg;

   localparam logic [2:0] FUNC_MUL   = 3'd0;
   localparam logic [2:0] FUNC_MLA   = 3'd1;
   localparam logic [2:0] FUNC_UMULL = 3'd2;
   localparam logic [2:0] FUNC_UMLAL = 3'd3;
   localparam logic [2:0] FUNC_SMULL = 3'd4;
   localparam logic [2:0] FUNC_SMLAL = 3'd5;

   typedef struct packed {
      logic [2:0]  func;
      logic        set_flags;
      logic [31:0] multiplicand;
      logic [31:0] multiplier;
      logic [31:0] addend_low;
      logic [31:0] addend_high;
   } req_type;

   typedef struct packed {
      logic [31:0] product_low;
      logic [31:0] product_high;
      logic        high_valid;
      logic        flags_write;
      logic        zero_flag;
      logic        negative_flag;
      logic        carry_flag;
   } rsp_type;

   // Side information that travels alongside the arithmetic.
   typedef struct packed {
      logic op_valid;
      logic is_long;
      logic set_flags;
   } ctrl_type;

   // Load enables of the arithmetic stages.
   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;

endpackage

// ----- rtl/core/multiply_accumulate_unit.sv -----
// Multiply-accumulate unit, top level: operand capture, pipeline control and
// result formatting. Depends on mau_pkg, mau_mult_pipe and assert_macros.svh.
//
// The unit takes one beat per clock cycle while req_stall is low. The five
// stages are operand capture (with the signed correction folded into the
// addend), the 16x16 partial products, the first accumulation, the final
// 64-bit sum, and the output register where flags are formed. Every stage
// carries its own valid bit and only holds when the stage after it is full
// and holding, so a stall on rsp_stall backs up through the pipeline one
// bubble at a time and req_stall rises only when all five stages hold a
// beat. Reserved operation codes still produce one result beat, with every
// field cleared.
`include "assert_macros.svh"

module multiply_accumulate_unit
   import mau_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Valid bits of the five stages; stage five is the output register.
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic en1, en5;
   stage_en_type stage_en;

   // Captured operands and the adjusted addend.
   logic [31:0] a1_ff, b1_ff;
   logic [63:0] acc1_ff, acc1_in;
   logic [31:0] corr;
   ctrl_type    ctrl1_ff, ctrl1_in, ctrl2_ff, ctrl3_ff, ctrl4_ff;

   logic [63:0] result;
   rsp_type     rsp_ff, rsp_in;

   // A stage may load when it is empty or when its own beat moves on.
   always_comb begin
      en5         = !v5_ff || !rsp_stall;
      stage_en.s4 = !v4_ff || en5;
      stage_en.s3 = !v3_ff || stage_en.s4;
      stage_en.s2 = !v2_ff || stage_en.s3;
      en1         = !v1_ff || stage_en.s2;
   end

   assign req_stall = !en1;
   assign rsp_valid = v5_ff;

   // Decode and addend selection. A signed product equals the unsigned one
   // less each operand times 2^32 where the other operand is negative, so
   // that correction is subtracted from the high addend word here and the
   // multiplier itself stays unsigned. Only the low word of the correction
   // survives the wrap at 64 bits.
   always_comb begin
      corr = ({32{req_data.multiplicand[31]}} & req_data.multiplier)
           + ({32{req_data.multiplier[31]}} & req_data.multiplicand);
      ctrl1_in.set_flags = req_data.set_flags;
      ctrl1_in.op_valid  = 1'b1;
      ctrl1_in.is_long   = 1'b1;
      acc1_in            = 64'd0;
      case (req_data.func)
         FUNC_MUL: begin
            ctrl1_in.is_long = 1'b0;
         end
         FUNC_MLA: begin
            ctrl1_in.is_long = 1'b0;
            acc1_in          = {32'd0, req_data.addend_low};
         end
         FUNC_UMULL: begin
            acc1_in = 64'd0;
         end
         FUNC_UMLAL: begin
            acc1_in = {req_data.addend_high, req_data.addend_low};
         end
         FUNC_SMULL: begin
            acc1_in = {32'd0 - corr, 32'd0};
         end
         FUNC_SMLAL: begin
            acc1_in = {req_data.addend_high - corr, req_data.addend_low};
         end
         default: begin
            ctrl1_in.op_valid = 1'b0;
            ctrl1_in.is_long  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1)         v1_ff <= req_valid;
         if (stage_en.s2) v2_ff <= v1_ff;
         if (stage_en.s3) v3_ff <= v2_ff;
         if (stage_en.s4) v4_ff <= v3_ff;
         if (en5)         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         a1_ff    <= req_data.multiplicand;
         b1_ff    <= req_data.multiplier;
         acc1_ff  <= acc1_in;
         ctrl1_ff <= ctrl1_in;
      end
      if (stage_en.s2) ctrl2_ff <= ctrl1_ff;
      if (stage_en.s3) ctrl3_ff <= ctrl2_ff;
      if (stage_en.s4) ctrl4_ff <= ctrl3_ff;
      if (en5)         rsp_ff   <= rsp_in;
   end

   mau_mult_pipe u_mult (
      .clock    (clock),
      .stage_en (stage_en),
      .op_a     (a1_ff),
      .op_b     (b1_ff),
      .acc      (acc1_ff),
      .result   (result)
   );

   // Result formatting. Short forms report only the low word and take their
   // flags from it; reserved codes clear everything.
   always_comb begin
      rsp_in.product_low   = ctrl4_ff.op_valid ? result[31:0] : 32'd0;
      rsp_in.high_valid    = ctrl4_ff.op_valid && ctrl4_ff.is_long;
      rsp_in.product_high  = rsp_in.high_valid ? result[63:32] : 32'd0;
      rsp_in.flags_write   = ctrl4_ff.op_valid && ctrl4_ff.set_flags;
      rsp_in.zero_flag     = rsp_in.flags_write &&
                             (ctrl4_ff.is_long ? (result == 64'd0)
                                               : (result[31:0] == 32'd0));
      rsp_in.negative_flag = rsp_in.flags_write &&
                             (ctrl4_ff.is_long ? result[63] : result[31]);
      rsp_in.carry_flag    = 1'b0;
   end

   assign rsp_data = rsp_ff;

   // The input side only holds off when every stage is occupied and the
   // output is being held.
   `ASSERT_IMPLIES(a_stall_only_when_full, clock, reset, req_stall,
      v1_ff && v2_ff && v3_ff && v4_ff && v5_ff && rsp_stall)
   // A finished beat in the last arithmetic stage reaches the output when it
   // is free.
   `ASSERT_IMPLIES_NEXT(a_result_advances, clock, reset, v4_ff && en5, rsp_valid)
   // The high word is only non-zero on beats that write it back.
   `ASSERT_IMPLIES(a_high_word_clear, clock, reset,
      rsp_valid && !rsp_data.high_valid, rsp_data.product_high == 32'd0)

endmodule

// ----- rtl/core/mau_mult_pipe.sv -----
// Three-stage unsigned 32x32 multiplier with a 64-bit addend folded in.
// Depends on mau_pkg for the stage enable bundle.
module mau_mult_pipe
   import mau_pkg::*;
(
   input  logic         clock,
   input  stage_en_type stage_en,
   input  logic [31:0]  op_a,
   input  logic [31:0]  op_b,
   input  logic [63:0]  acc,
   output logic [63:0]  result
);

   logic [31:0] pp_ll_ff, pp_lh_ff, pp_hl_ff, pp_hh_ff;
   logic [31:0] pp_ll_in, pp_lh_in, pp_hl_in, pp_hh_in;
   logic [63:0] acc2_ff;
   logic [63:0] sum_ff, sum_in;
   logic [32:0] mid_ff, mid_in;
   logic [63:0] res_ff, res_in;

   // Four 16x16 partial products.
   always_comb begin
      pp_ll_in = op_a[15:0]  * op_b[15:0];
      pp_lh_in = op_a[15:0]  * op_b[31:16];
      pp_hl_in = op_a[31:16] * op_b[15:0];
      pp_hh_in = op_a[31:16] * op_b[31:16];
   end

   // The outer partial products line up without overlap, so they are
   // concatenated and added to the addend in one pass.
   always_comb begin
      sum_in = {pp_hh_ff, pp_ll_ff} + acc2_ff;
      mid_in = {1'b0, pp_lh_ff} + {1'b0, pp_hl_ff};
   end

   always_comb begin
      res_in = sum_ff + {15'd0, mid_ff, 16'd0};
   end

   always_ff @(posedge clock) begin
      if (stage_en.s2) begin
         pp_ll_ff <= pp_ll_in;
         pp_lh_ff <= pp_lh_in;
         pp_hl_ff <= pp_hl_in;
         pp_hh_ff <= pp_hh_in;
         acc2_ff  <= acc;
      end
      if (stage_en.s3) begin
         sum_ff <= sum_in;
         mid_ff <= mid_in;
      end
      if (stage_en.s4) begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule
